### hw/rtl/clkalm_pkg.sv
package clkalm_pkg;

    localparam int LAP_DEPTH_DEF   = 5;
    localparam int ALARM_COUNT_DEF = 5;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int ALARM_W    = 17;
    localparam int NOTE_W     = 8;
    localparam int LOAD_W     = 7;
    localparam int LAP_IDX_W  = 3;

    localparam logic [NOTE_W-1:0] NOTE_LIMIT_RST = 8'd50;

    localparam logic [4:0] HOURS_PER_DAY = 5'd24;
    localparam logic [5:0] MINUTE_LAST   = 6'd59;
    localparam logic [5:0] SECOND_LAST   = 6'd59;
    localparam logic [5:0] UNITS_60      = 6'd60;
    localparam logic [3:0] TENTHS        = 4'd10;
    localparam logic [3:0] TENTH_LAST    = 4'd9;

    typedef enum logic [3:0] {
        OP_TICK        = 4'd0,
        OP_SET_CLOCK   = 4'd1,
        OP_WATCH_RUN   = 4'd2,
        OP_WATCH_PAUSE = 4'd3,
        OP_WATCH_CLEAR = 4'd4,
        OP_LAP_RECORD  = 4'd5,
        OP_LAP_READ    = 4'd6,
        OP_TIMER_RUN   = 4'd7,
        OP_TIMER_PAUSE = 4'd8,
        OP_TIMER_CLEAR = 4'd9,
        OP_TIMER_SET   = 4'd10,
        OP_SILENCE     = 4'd11
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALARM_ZERO  = 3'd0,
        REG_ALARM_ONE   = 3'd1,
        REG_ALARM_TWO   = 3'd2,
        REG_ALARM_THREE = 3'd3,
        REG_ALARM_FOUR  = 3'd4,
        REG_NOTE_LIMIT  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [3:0] tenth;
    } t_hmst;

    typedef struct packed {
        logic [3:0]           pad;
        logic [LAP_IDX_W-1:0] lap_index;
        logic [LOAD_W-1:0]    load_second;
        logic [LOAD_W-1:0]    load_minute;
        logic [LOAD_W-1:0]    load_hour;
        logic [3:0]           operation;
    } t_in_item;

    typedef struct packed {
        logic       timer_done;
        logic       alarm_hit;
        logic       sound_on;
        logic [3:0] show_tenth;
        logic [5:0] show_second;
        logic [5:0] show_minute;
        logic [4:0] show_hour;
    } t_out_item;

endpackage

### hw/rtl/clock_alarm_stopwatch_timer.sv
// Tenth-second timekeeper: 24-hour clock with alarms, a stopwatch with a lap
// store and a countdown timer. Every input transfer carries one operation and
// produces exactly one output transfer. An operation is held in an input
// register, then its state update and result are written in a single step to
// the output register, so a new operation is taken every cycle while the
// output side is ready. The output register lets the next operation in while
// a result is still waiting.
// Alarm and note-limit registers are written through the cfg port and should
// only change while no operation is in flight.
module clock_alarm_stopwatch_timer #(
    parameter int LAP_DEPTH   = clkalm_pkg::LAP_DEPTH_DEF,
    parameter int ALARM_COUNT = clkalm_pkg::ALARM_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // operation, load_hour, load_minute, load_second, lap_index, zero pad
    input  logic [clkalm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // show_hour, show_minute, show_second, show_tenth, sound_on, alarm_hit,
    // timer_done
    output logic [clkalm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [clkalm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [clkalm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import clkalm_pkg::*;

    t_in_item           r_in;
    logic               r_in_vld;
    t_out_item          r_out;
    logic               r_out_vld;

    logic [ALARM_W-1:0] r_alarm [ALARM_COUNT];
    logic [NOTE_W-1:0]  r_note_limit;

    t_hmst              r_clk, r_watch, r_cnt;
    logic               r_watch_run, r_cnt_run, r_cnt_exp;
    logic               r_sound;
    logic [NOTE_W-1:0]  r_notes;
    t_hmst              r_lap [LAP_DEPTH];

    t_hmst              n_clk, n_watch, n_cnt;
    logic               n_watch_run, n_cnt_run, n_cnt_exp;
    logic               n_sound;
    logic [NOTE_W-1:0]  n_notes;
    logic               n_lap_push;
    t_out_item          n_out;

    logic               step;
    logic               out_free;

    function automatic t_hmst f_advance(input t_hmst v);
        t_hmst r;
        r = v;
        r.tenth = v.tenth + 4'd1;
        if (r.tenth >= TENTHS) begin
            r.tenth  = '0;
            r.second = v.second + 6'd1;
        end
        if (r.second >= UNITS_60) begin
            r.second = '0;
            r.minute = v.minute + 6'd1;
        end
        if (r.minute >= UNITS_60) begin
            r.minute = '0;
            r.hour   = v.hour + 5'd1;
        end
        if (r.hour >= HOURS_PER_DAY) begin
            r.hour = '0;
        end
        return r;
    endfunction

    function automatic t_hmst f_countdown(input t_hmst v, input logic expired);
        t_hmst r;
        r = v;
        r.tenth = expired ? 4'd0 : v.tenth;
        if (r.tenth == 4'd0) begin
            if (v.second != '0) begin
                r.second = v.second - 6'd1;
                r.tenth  = TENTH_LAST;
            end else if (v.minute != '0) begin
                r.minute = v.minute - 6'd1;
                r.second = SECOND_LAST;
                r.tenth  = TENTH_LAST;
            end else if (v.hour != '0) begin
                r.hour   = v.hour - 5'd1;
                r.minute = MINUTE_LAST;
                r.second = SECOND_LAST;
                r.tenth  = TENTH_LAST;
            end
        end else begin
            r.tenth = r.tenth - 4'd1;
        end
        return r;
    endfunction

    function automatic t_hmst f_load(input t_hmst v, input t_in_item it);
        t_hmst r;
        r = v;
        if (it.load_hour < LOAD_W'(HOURS_PER_DAY)) r.hour = it.load_hour[4:0];
        if (it.load_minute < LOAD_W'(UNITS_60)) r.minute = it.load_minute[5:0];
        if (it.load_second < LOAD_W'(UNITS_60)) r.second = it.load_second[5:0];
        return r;
    endfunction

    assign out_free      = !r_out_vld || m_axis_tready;
    assign step          = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || out_free;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    always_comb begin
        t_hmst            show;
        t_hmst            lap_sel_entry;
        logic [4:0]       lap_sel;
        logic             hit;
        logic [ALARM_W-1:0] a;

        n_clk       = r_clk;
        n_watch     = r_watch;
        n_cnt       = r_cnt;
        n_watch_run = r_watch_run;
        n_cnt_run   = r_cnt_run;
        n_cnt_exp   = r_cnt_exp;
        n_sound     = r_sound;
        n_notes     = r_notes;
        n_lap_push  = 1'b0;
        hit         = 1'b0;
        show        = r_clk;
        a           = '0;

        lap_sel = ({2'b00, r_in.lap_index} >= 5'(LAP_DEPTH)) ?
                  5'(LAP_DEPTH - 1) : {2'b00, r_in.lap_index};
        lap_sel_entry = r_lap[0];
        for (int i = 0; i < LAP_DEPTH; i++) begin
            if (lap_sel == 5'(i)) lap_sel_entry = r_lap[i];
        end

        unique case (r_in.operation)
            OP_TICK: begin
                if (r_sound) begin
                    n_notes = r_notes + 8'd1;
                    if (n_notes == r_note_limit) begin
                        n_sound = 1'b0;
                        n_notes = '0;
                    end
                end
                n_clk = f_advance(r_clk);
                if (n_clk.hour != '0 || n_clk.minute != '0 || n_clk.second != '0) begin
                    for (int i = 0; i < ALARM_COUNT; i++) begin
                        a = r_alarm[i];
                        if (n_clk.hour == a[16:12] && n_clk.minute == a[11:6] &&
                            n_clk.second == a[5:0]) begin
                            hit = 1'b1;
                        end
                    end
                end
                if (hit) begin
                    n_sound = 1'b1;
                    n_notes = '0;
                end
                if (r_watch_run) n_watch = f_advance(r_watch);
                if (r_cnt_run) begin
                    n_cnt     = f_countdown(r_cnt, r_cnt_exp);
                    n_cnt_exp = (n_cnt == '0);
                    if (n_cnt_exp) n_sound = 1'b1;
                end
                show = n_clk;
            end
            OP_SET_CLOCK: begin
                n_clk = f_load(r_clk, r_in);
                show  = n_clk;
            end
            OP_WATCH_RUN: begin
                n_watch_run = 1'b1;
                show        = r_watch;
            end
            OP_WATCH_PAUSE: begin
                n_watch_run = 1'b0;
                show        = r_watch;
            end
            OP_WATCH_CLEAR: begin
                n_watch_run = 1'b0;
                n_watch     = '0;
                show        = '0;
            end
            OP_LAP_RECORD: begin
                n_lap_push = 1'b1;
                show       = r_watch;
            end
            OP_LAP_READ: begin
                show = lap_sel_entry;
            end
            OP_TIMER_RUN: begin
                n_cnt_run = 1'b1;
                show      = r_cnt;
            end
            OP_TIMER_PAUSE: begin
                n_cnt_run = 1'b0;
                n_sound   = 1'b0;
                show      = r_cnt;
            end
            OP_TIMER_CLEAR: begin
                n_cnt_run = 1'b0;
                n_sound   = 1'b0;
                n_cnt_exp = 1'b0;
                n_cnt     = '0;
                show      = '0;
            end
            OP_TIMER_SET: begin
                n_cnt = f_load(r_cnt, r_in);
                if (r_cnt_exp) n_cnt.tenth = '0;
                n_cnt_exp = 1'b0;
                show      = n_cnt;
            end
            OP_SILENCE: begin
                n_sound = 1'b0;
                n_notes = '0;
            end
            default: begin
                show = r_clk;
            end
        endcase

        if (r_in.operation == OP_TIMER_RUN || r_in.operation == OP_TIMER_PAUSE) begin
            if (r_cnt_exp) show.tenth = '0;
        end

        n_out.show_hour   = show.hour;
        n_out.show_minute = show.minute;
        n_out.show_second = show.second;
        n_out.show_tenth  = show.tenth;
        n_out.sound_on    = n_sound;
        n_out.alarm_hit   = hit;
        n_out.timer_done  = n_cnt_exp;
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_note_limit <= NOTE_LIMIT_RST;
            r_clk        <= '0;
            r_watch      <= '0;
            r_cnt        <= '0;
            r_watch_run  <= 1'b0;
            r_cnt_run    <= 1'b0;
            r_cnt_exp    <= 1'b0;
            r_sound      <= 1'b0;
            r_notes      <= '0;
            for (int i = 0; i < ALARM_COUNT; i++) r_alarm[i] <= '0;
            for (int i = 0; i < LAP_DEPTH; i++) r_lap[i] <= '0;
        end else begin
            if (s_axis_tready) r_in_vld <= s_axis_tvalid;
            if (out_free) r_out_vld <= r_in_vld;

            if (i_cfg_we) begin
                for (int i = 0; i < ALARM_COUNT; i++) begin
                    if (i_cfg_idx == CFG_IDX_W'(i)) r_alarm[i] <= i_cfg_data[ALARM_W-1:0];
                end
                if (i_cfg_idx == REG_NOTE_LIMIT) r_note_limit <= i_cfg_data[NOTE_W-1:0];
            end

            if (step) begin
                r_clk       <= n_clk;
                r_watch     <= n_watch;
                r_cnt       <= n_cnt;
                r_watch_run <= n_watch_run;
                r_cnt_run   <= n_cnt_run;
                r_cnt_exp   <= n_cnt_exp;
                r_sound     <= n_sound;
                r_notes     <= n_notes;
                if (n_lap_push) begin
                    for (int i = LAP_DEPTH - 1; i > 0; i--) r_lap[i] <= r_lap[i-1];
                    r_lap[0] <= r_watch;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) r_in <= t_in_item'(s_axis_tdata);
        if (step) r_out <= n_out;
    end

endmodule

### verif/tb_clock_alarm_stopwatch_timer.sv
module tb_clock_alarm_stopwatch_timer;

    import clkalm_pkg::*;

    localparam int DRAIN_CYCLES = 6;
    localparam int TIMEOUT      = 400000;
    localparam int LONG_HOLD    = 300;

    class timekeeper_scoreboard;
        logic [ALARM_W-1:0] alarm_time [5];
        logic [NOTE_W-1:0]  note_limit;
        t_hmst              clock_now;
        t_hmst              watch_now;
        t_hmst              count_now;
        t_hmst              laps [LAP_DEPTH_DEF];
        logic               watch_on;
        logic               count_on;
        logic               count_zero;
        logic               sound;
        logic [NOTE_W-1:0]  notes;
        t_out_item          expected_q [$];
        int                 checked;

        function new();
            foreach (alarm_time[k]) alarm_time[k] = '0;
            foreach (laps[k]) laps[k] = '0;
            note_limit = NOTE_LIMIT_RST;
            clock_now  = '0;
            watch_now  = '0;
            count_now  = '0;
            watch_on   = 1'b0;
            count_on   = 1'b0;
            count_zero = 1'b0;
            sound      = 1'b0;
            notes      = '0;
            checked    = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_NOTE_LIMIT)
                note_limit = val[NOTE_W-1:0];
            else
                alarm_time[idx] = val;
        endfunction

        function t_hmst step_up(t_hmst v);
            v.tenth = v.tenth + 4'd1;
            if (v.tenth >= TENTHS) begin
                v.tenth  = '0;
                v.second = v.second + 6'd1;
            end
            if (v.second >= UNITS_60) begin
                v.second = '0;
                v.minute = v.minute + 6'd1;
            end
            if (v.minute >= UNITS_60) begin
                v.minute = '0;
                v.hour   = v.hour + 5'd1;
            end
            if (v.hour >= HOURS_PER_DAY) v.hour = '0;
            return v;
        endfunction

        // each field loads on its own, the tenth never changes
        function t_hmst loaded(t_hmst v, t_in_item it);
            if (it.load_hour < HOURS_PER_DAY) v.hour = it.load_hour[4:0];
            if (it.load_minute < UNITS_60) v.minute = it.load_minute[5:0];
            if (it.load_second < UNITS_60) v.second = it.load_second[5:0];
            return v;
        endfunction

        function void count_down();
            logic [3:0] t;
            t = count_zero ? 4'd0 : count_now.tenth;
            if (t == 4'd0) begin
                if (count_now.second > 0) begin
                    count_now.second = count_now.second - 6'd1;
                    t = TENTHS;
                end else if (count_now.minute > 0) begin
                    count_now.minute = count_now.minute - 6'd1;
                    count_now.second = SECOND_LAST;
                    t = TENTHS;
                end else if (count_now.hour > 0) begin
                    count_now.hour   = count_now.hour - 5'd1;
                    count_now.minute = MINUTE_LAST;
                    count_now.second = SECOND_LAST;
                    t = TENTHS;
                end
            end
            if (t > 4'd0) t = t - 4'd1;
            count_now.tenth = t;
            count_zero = (count_now.hour == 0 && count_now.minute == 0 &&
                          count_now.second == 0 && t == 4'd0);
        endfunction

        function t_hmst timer_view();
            t_hmst v;
            v = count_now;
            if (count_zero) v.tenth = '0;
            return v;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            t_hmst     shown;
            logic      hit;
            int        k;
            shown = clock_now;
            hit   = 1'b0;
            case (it.operation)
                OP_TICK: begin
                    if (sound) begin
                        notes = notes + 8'd1;
                        if (notes == note_limit) begin
                            sound = 1'b0;
                            notes = '0;
                        end
                    end
                    clock_now = step_up(clock_now);
                    if (clock_now.hour != 0 || clock_now.minute != 0 || clock_now.second != 0)
                        for (k = 0; k < ALARM_COUNT_DEF; k++)
                            if (clock_now.hour == alarm_time[k][16:12] &&
                                clock_now.minute == alarm_time[k][11:6] &&
                                clock_now.second == alarm_time[k][5:0]) begin
                                sound = 1'b1;
                                notes = '0;
                                hit   = 1'b1;
                            end
                    if (watch_on) watch_now = step_up(watch_now);
                    if (count_on) begin
                        count_down();
                        if (count_zero) sound = 1'b1;
                    end
                    shown = clock_now;
                end
                OP_SET_CLOCK: begin
                    clock_now = loaded(clock_now, it);
                    shown = clock_now;
                end
                OP_WATCH_RUN: begin
                    watch_on = 1'b1;
                    shown = watch_now;
                end
                OP_WATCH_PAUSE: begin
                    watch_on = 1'b0;
                    shown = watch_now;
                end
                OP_WATCH_CLEAR: begin
                    watch_on  = 1'b0;
                    watch_now = '0;
                    shown = watch_now;
                end
                OP_LAP_RECORD: begin
                    for (k = LAP_DEPTH_DEF - 1; k > 0; k--) laps[k] = laps[k-1];
                    laps[0] = watch_now;
                    shown = watch_now;
                end
                OP_LAP_READ: begin
                    k = (int'(it.lap_index) >= LAP_DEPTH_DEF) ? LAP_DEPTH_DEF - 1 :
                        int'(it.lap_index);
                    shown = laps[k];
                end
                OP_TIMER_RUN: begin
                    count_on = 1'b1;
                    shown = timer_view();
                end
                OP_TIMER_PAUSE: begin
                    count_on = 1'b0;
                    sound    = 1'b0;
                    shown = timer_view();
                end
                OP_TIMER_CLEAR: begin
                    count_on   = 1'b0;
                    sound      = 1'b0;
                    count_zero = 1'b0;
                    count_now  = '0;
                    shown = timer_view();
                end
                OP_TIMER_SET: begin
                    count_now = loaded(count_now, it);
                    if (count_zero) count_now.tenth = '0;
                    count_zero = 1'b0;
                    shown = timer_view();
                end
                OP_SILENCE: begin
                    sound = 1'b0;
                    notes = '0;
                end
                default: ;
            endcase
            r.show_hour   = shown.hour;
            r.show_minute = shown.minute;
            r.show_second = shown.second;
            r.show_tenth  = shown.tenth;
            r.sound_on    = sound;
            r.alarm_hit   = hit;
            r.timer_done  = count_zero;
            expected_q.push_back(r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function string check_result(t_out_item got);
            t_out_item want;
            string     bad;
            checked++;
            if (expected_q.size() == 0)
                return $sformatf("result %0d (%h) arrived with nothing expected", checked, got);
            want = expected_q.pop_front();
            bad = "";
            if (got.show_hour !== want.show_hour) bad = {bad, " show_hour"};
            if (got.show_minute !== want.show_minute) bad = {bad, " show_minute"};
            if (got.show_second !== want.show_second) bad = {bad, " show_second"};
            if (got.show_tenth !== want.show_tenth) bad = {bad, " show_tenth"};
            if (got.sound_on !== want.sound_on) bad = {bad, " sound_on"};
            if (got.alarm_hit !== want.alarm_hit) bad = {bad, " alarm_hit"};
            if (got.timer_done !== want.timer_done) bad = {bad, " timer_done"};
            if (bad == "") return "";
            return $sformatf("result %0d wrong in%s: got %h want %h", checked, bad, got, want);
        endfunction
    endclass

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_HALF, RX_EVERY_FOURTH} t_rx_mode;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire  [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    timekeeper_scoreboard   tracker = new();
    logic [ALARM_W-1:0]     alarm_cfg [5];
    int                     items_sent;
    int                     results_seen;
    int                     hits_seen;
    int                     expired_seen;
    int                     errors;
    int                     settings_used;
    int                     burst_left;
    int                     rx_hold;
    int                     rx_left;
    int                     rx_cycle;
    t_rx_mode               rx_mode;
    string                  mismatch_msg;
    t_out_item              got_item;

    clock_alarm_stopwatch_timer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    task automatic report(input string msg);
        errors++;
        $display("ERROR: %s", msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_item = m_axis_tdata;
            results_seen++;
            if (got_item.alarm_hit === 1'b1) hits_seen++;
            if (got_item.timer_done === 1'b1) expired_seen++;
            mismatch_msg = tracker.check_result(got_item);
            if (mismatch_msg != "") report(mismatch_msg);
        end
    end

    // receiver stall pattern, long hold-off counted here
    initial begin
        rx_left  = 0;
        rx_cycle = 0;
        rx_mode  = RX_OPEN;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    rx_left = $urandom_range(20, 80);
                end
                rx_left--;
                case (rx_mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                    default:   m_axis_tready <= (rx_cycle % 4 != 0);
                endcase
            end
        end
    end

    initial begin
        #(TIMEOUT);
        $display("Some tests failed");
        $finish;
    end

    function automatic t_in_item make_item(logic [3:0] op);
        t_in_item it;
        it.pad         = '0;
        it.operation   = op;
        it.load_hour   = LOAD_W'($urandom_range(0, 127));
        it.load_minute = LOAD_W'($urandom_range(0, 127));
        it.load_second = LOAD_W'($urandom_range(0, 127));
        it.lap_index   = LAP_IDX_W'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic logic [ALARM_W-1:0] hms(int h, int m, int s);
        return {h[4:0], m[5:0], s[5:0]};
    endfunction

    function automatic logic [ALARM_W-1:0] rand_alarm();
        return hms($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    // bursts of random length, random gaps between them
    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_input(it);
        items_sent++;
    endtask

    task automatic send_op(input logic [3:0] op);
        send_item(make_item(op));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_op(OP_TICK);
    endtask

    task automatic send_load(input logic [3:0] op, input int h, input int m, input int s);
        t_in_item it;
        it = make_item(op);
        it.load_hour   = LOAD_W'(h);
        it.load_minute = LOAD_W'(m);
        it.load_second = LOAD_W'(s);
        send_item(it);
    endtask

    task automatic send_read(input int idx);
        t_in_item it;
        it = make_item(OP_LAP_READ);
        it.lap_index = LAP_IDX_W'(idx);
        send_item(it);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_reg(idx, val);
        if (idx != REG_NOTE_LIMIT) alarm_cfg[idx] = val;
    endtask

    task automatic set_alarms(input logic [ALARM_W-1:0] a0, input logic [ALARM_W-1:0] a1,
                              input logic [ALARM_W-1:0] a2, input logic [ALARM_W-1:0] a3,
                              input logic [ALARM_W-1:0] a4, input logic [NOTE_W-1:0] limit);
        write_reg(REG_ALARM_ZERO, a0);
        write_reg(REG_ALARM_ONE, a1);
        write_reg(REG_ALARM_TWO, a2);
        write_reg(REG_ALARM_THREE, a3);
        write_reg(REG_ALARM_FOUR, a4);
        write_reg(REG_NOTE_LIMIT, CFG_DATA_W'(limit));
        settings_used++;
    endtask

    // park the clock one second before an alarm (on it when its second is zero) and tick on
    task automatic alarm_approach(input int ticks);
        logic [ALARM_W-1:0] a;
        int                 s;
        a = alarm_cfg[$urandom_range(0, 4)];
        s = int'(a[5:0]);
        send_load(OP_SET_CLOCK, int'(a[16:12]), int'(a[11:6]), (s > 0) ? s - 1 : s);
        send_ticks(ticks);
    endtask

    task automatic run_sequence();
        int pick;
        int r;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            alarm_approach($urandom_range(5, 25));
        end else if (pick < 40) begin
            send_load(OP_TIMER_SET, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : 0,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : 0,
                      $urandom_range(0, 3));
            send_op(OP_TIMER_RUN);
            send_ticks($urandom_range(3, 40));
            r = $urandom_range(0, 3);
            if (r == 0) send_op(OP_TIMER_PAUSE);
            else if (r == 1) send_op(OP_TIMER_CLEAR);
            else if (r == 2) send_load(OP_TIMER_SET, $urandom_range(0, 30),
                                       $urandom_range(0, 70), $urandom_range(0, 70));
        end else if (pick < 55) begin
            send_op(OP_WATCH_RUN);
            send_ticks($urandom_range(2, 15));
            send_op(OP_LAP_RECORD);
            send_ticks($urandom_range(0, 8));
            send_op(OP_LAP_RECORD);
            send_read($urandom_range(0, 7));
            send_read($urandom_range(0, 7));
            if ($urandom_range(0, 1) == 1) send_op(OP_WATCH_PAUSE);
            else if ($urandom_range(0, 2) == 0) send_op(OP_WATCH_CLEAR);
        end else if (pick < 65) begin
            send_ticks($urandom_range(1, 6));
            send_op(OP_SILENCE);
        end else if (pick < 85) begin
            send_ticks($urandom_range(5, 20));
        end else begin
            repeat ($urandom_range(1, 6)) send_op(4'($urandom_range(0, 15)));
        end
    endtask

    task automatic run_random(input int quota, input bit long_hold, input bit mid_pause);
        int target;
        int half;
        bit paused;
        target = items_sent + quota;
        half   = items_sent + quota / 2;
        paused = 1'b0;
        if (long_hold) rx_hold = LONG_HOLD;
        while (items_sent < target) begin
            if (mid_pause && !paused && items_sent >= half) begin
                wait_for_results();
                paused = 1'b1;
            end
            run_sequence();
        end
    endtask

    initial begin
        foreach (alarm_cfg[k]) alarm_cfg[k] = '0;
        items_sent    = 0;
        results_seen  = 0;
        hits_seen     = 0;
        expired_seen  = 0;
        errors        = 0;
        settings_used = 0;
        burst_left    = 0;
        rx_hold       = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_alarms(hms(23, 59, 59), hms(0, 0, 1), '1, hms(24, 0, 0), hms(12, 34, 56), 8'd3);

        // directed: day wrap with alarm, stopwatch and laps, loads, timer borrow and expiry
        send_op(OP_WATCH_RUN);
        send_load(OP_SET_CLOCK, 23, 59, 59);
        send_ticks(10);
        send_op(OP_LAP_RECORD);
        send_op(OP_WATCH_PAUSE);
        send_read(0);
        send_read(7);
        send_op(OP_WATCH_CLEAR);
        send_load(OP_SET_CLOCK, 99, 127, 30);
        send_load(OP_TIMER_SET, 1, 0, 0);
        send_op(OP_TIMER_RUN);
        send_op(OP_TICK);
        send_op(OP_TIMER_PAUSE);
        send_load(OP_TIMER_SET, 0, 0, 0);
        send_op(OP_TIMER_RUN);
        send_op(OP_TICK);
        send_load(OP_TIMER_SET, 0, 0, 1);
        send_op(OP_SILENCE);
        send_op(OP_TIMER_CLEAR);
        wait_for_results();

        set_alarms(rand_alarm(), rand_alarm(), rand_alarm(), rand_alarm(), rand_alarm(), 8'd1);
        run_random(220, 1'b0, 1'b1);
        wait_for_results();

        // note limit of zero: ring for the full wrap of the note count
        set_alarms(rand_alarm(), rand_alarm(), rand_alarm(), rand_alarm(), rand_alarm(), 8'd0);
        send_op(OP_TIMER_CLEAR);
        send_op(OP_SILENCE);
        alarm_approach(280);
        run_random(20, 1'b0, 1'b0);
        wait_for_results();

        set_alarms('0, '1, hms(23, 59, 59), hms(0, 60, 0), hms(0, 0, 63), 8'd255);
        run_random(180, 1'b0, 1'b0);
        wait_for_results();

        set_alarms(($urandom_range(0, 3) == 0) ? ALARM_W'($urandom()) : rand_alarm(),
                   ($urandom_range(0, 3) == 0) ? ALARM_W'($urandom()) : rand_alarm(),
                   ($urandom_range(0, 3) == 0) ? ALARM_W'($urandom()) : rand_alarm(),
                   ($urandom_range(0, 3) == 0) ? ALARM_W'($urandom()) : rand_alarm(),
                   rand_alarm(), NOTE_W'($urandom_range(2, 60)));
        run_random(220, 1'b1, 1'b0);
        wait_for_results();

        $display("covered %0d operations under %0d register settings, %0d results checked",
                 items_sent, settings_used, results_seen);
        $display("saw %0d alarm hits and %0d results with the timer expired",
                 hits_seen, expired_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
